// ----- rtl/lds_pkg.sv -----
// Shared types, register codes and the clamp helper for the latency delta smoother.
// No dependencies; used by lds_cfg, lds_hist, the top level and the testbench.
`default_nettype none

package lds_pkg;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_BYPASS = 2'd0;
    localparam logic [1:0] REG_SNAP   = 2'd1;
    localparam logic [1:0] REG_FINE   = 2'd2;
    localparam logic [1:0] REG_MAX    = 2'd3;

    typedef struct packed {
        logic               bypass;
        logic [9:0]         snap_frame_time;
        logic signed [10:0] fine_nudge;
        logic [14:0]        max_delta;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic push;
    } t_hist_cmd;

    // hold v within [-lim, 0]
    function automatic logic signed [15:0] clamp_delta(input logic signed [17:0] v,
                                                       input logic [14:0] lim);
        logic signed [17:0] neg_lim;
        logic signed [17:0] r;
        neg_lim = -$signed({3'b000, lim});
        if (v < neg_lim) begin
            r = neg_lim;
        end else if (v > 18'sd0) begin
            r = 18'sd0;
        end else begin
            r = v;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lds_cfg.sv -----
// APB register file: bypass, snap frame time, fine nudge and clamp limit.
// Depends on lds_pkg.
`default_nettype none

module lds_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lds_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output lds_pkg::t_cfg                     o_cfg
);

    lds_pkg::t_cfg r_cfg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bypass          <= 1'b0;
            r_cfg.snap_frame_time <= 10'd100;
            r_cfg.fine_nudge      <= 11'sd0;
            r_cfg.max_delta       <= 15'd300;
        end else if (wr) begin
            case (paddr[3:2])
                lds_pkg::REG_BYPASS: r_cfg.bypass          <= pwdata[0];
                lds_pkg::REG_SNAP:   r_cfg.snap_frame_time <= pwdata[9:0];
                lds_pkg::REG_FINE:   r_cfg.fine_nudge      <= $signed(pwdata[10:0]);
                lds_pkg::REG_MAX:    r_cfg.max_delta       <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lds_pkg::REG_BYPASS: prdata = {31'd0, r_cfg.bypass};
            lds_pkg::REG_SNAP:   prdata = {22'd0, r_cfg.snap_frame_time};
            lds_pkg::REG_FINE:   prdata = {21'd0, r_cfg.fine_nudge};
            lds_pkg::REG_MAX:    prdata = {17'd0, r_cfg.max_delta};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lds_hist.sv -----
// Delta history memory with fill count; walks the valid entries summing negatives.
// Depends on lds_pkg.
`default_nettype none

module lds_hist #(
    parameter int unsigned WINDOW = 6,
    parameter int unsigned CW     = $clog2(WINDOW + 1),
    parameter int unsigned SW     = 16 + CW
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lds_pkg::t_hist_cmd     i_cmd,
    input  wire logic signed [15:0]     i_push_data,
    output logic                        o_done,
    output logic signed [SW-1:0]        o_sum,
    output logic [CW-1:0]               o_cnt
);

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic signed [15:0]   mem [WINDOW];
    logic signed [15:0]   r_rd_data;
    logic [AW-1:0]        r_wptr;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_idx;
    logic                 r_busy;
    logic                 r_pend;
    logic signed [SW-1:0] r_sum;
    logic [CW-1:0]        r_cnt;
    logic                 rd_en;

    assign rd_en  = r_busy && (r_idx < r_fill);
    assign o_done = r_busy && (r_idx == r_fill) && !r_pend;
    assign o_sum  = r_sum;
    assign o_cnt  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wptr] <= i_push_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_fill <= '0;
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_idx  <= '0;
            r_sum  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_wptr <= (r_wptr == AW'(WINDOW - 1)) ? '0 : r_wptr + 1'b1;
                if (r_fill != CW'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_pend <= 1'b0;
                r_idx  <= '0;
                r_sum  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_pend && r_rd_data[15]) begin
                    r_sum <= r_sum + {{CW{r_rd_data[15]}}, r_rd_data};
                    r_cnt <= r_cnt + 1'b1;
                end
                if (o_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lds_div.sv -----
// Restoring divider, one quotient bit per cycle, for the window average.
// No dependencies.
`default_nettype none

module lds_div #(
    parameter int unsigned NW = 18,
    parameter int unsigned DW = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [NW-1:0]   i_dividend,
    input  wire logic [DW-1:0]   i_divisor,
    output logic                 o_done,
    output logic [NW-1:0]        o_quot
);

    localparam int unsigned SCW = $clog2(NW + 1);

    logic [DW:0]    r_rem;
    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_div;
    logic [SCW-1:0] r_step;
    logic           r_done;
    logic [DW:0]    rem_sh;
    logic           ge;

    assign rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= SCW'(NW);
            end else if (r_step != '0) begin
                r_step <= r_step - 1'b1;
                r_done <= (r_step == SCW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_step != '0) begin
            r_rem <= ge ? rem_sh - {1'b0, r_div} : rem_sh;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/latency_delta_smoother_unit.sv -----
// Latency delta smoother top level: sequencer, nudge and clamp, output register.
// Depends on lds_pkg, lds_cfg, lds_hist and lds_div.
//
// Usage: raw deltas enter on s_axis (16-bit two's complement word), one smoothed
// delta leaves on m_axis per input word. Registers must be written over the APB
// port only while the block is idle; the block does not enforce this. One word is
// processed at a time; s_axis_tready is high whenever the sequencer is idle, even
// if a result still waits on m_axis. Sequence: a word first walks the history
// memory, one read a cycle; when any entry read is negative, the average of the
// negative entries is then formed in the divider; last the output register is
// loaded. In bypass the walk and the divider are skipped. The next word can be
// taken in the cycle after the output register loads.
// Reset empties the history (fill count zero) and loads register defaults; memory
// contents are not cleared. If m_axis stalls, the finished result is held in the
// sequencer until the output register frees, and no new word is taken meanwhile.
`default_nettype none

module latency_delta_smoother_unit #(
    parameter int unsigned WINDOW = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic signed [15:0]           s_axis_tdata,  // [15:0] new_time_delta
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic signed [15:0]                m_axis_tdata,  // [15:0] smoothed_delta
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lds_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int unsigned CW = $clog2(WINDOW + 1);
    localparam int unsigned SW = 16 + CW;
    localparam int unsigned MW = SW - 1;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_OUT} t_state;

    lds_pkg::t_cfg      cfg;
    lds_pkg::t_hist_cmd hcmd;
    t_state             r_state;
    logic signed [15:0] r_nd;
    logic signed [15:0] r_res;
    logic               r_byp;
    logic               r_ovalid;
    logic signed [15:0] r_odata;
    logic               h_done;
    logic signed [SW-1:0] h_sum;
    logic [CW-1:0]      h_cnt;
    logic signed [SW-1:0] neg_sum;
    logic               d_start;
    logic               d_done;
    logic [MW-1:0]      d_quot;
    logic               accept;
    logic               out_free;
    logic signed [17:0] nd_raw;
    logic signed [17:0] avg;
    logic signed [17:0] s_tot;
    logic signed [17:0] half;

    lds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lds_hist #(.WINDOW(WINDOW)) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (hcmd),
        .i_push_data (r_nd),
        .o_done      (h_done),
        .o_sum       (h_sum),
        .o_cnt       (h_cnt)
    );

    lds_div #(.NW(MW), .DW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_dividend (neg_sum[MW-1:0]),
        .i_divisor  (h_cnt),
        .o_done     (d_done),
        .o_quot     (d_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign hcmd.start = accept && !cfg.bypass;
    assign hcmd.push  = (r_state == S_OUT) && out_free && !r_byp;
    assign d_start    = (r_state == S_WALK) && h_done && (h_cnt != '0);
    assign neg_sum    = -h_sum;

    assign nd_raw = {{2{s_axis_tdata[15]}}, s_axis_tdata}
                  + {9'd0, cfg.snap_frame_time[9:1]}
                  + {{7{cfg.fine_nudge[10]}}, cfg.fine_nudge};

    // average is never positive; half-sum truncates toward zero
    assign avg   = -$signed({2'b00, d_quot[15:0]});
    assign s_tot = avg + {{2{r_nd[15]}}, r_nd};
    assign half  = (s_tot + $signed({17'd0, s_tot[17] & s_tot[0]})) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_byp <= cfg.bypass;
                        r_nd  <= lds_pkg::clamp_delta(nd_raw, cfg.max_delta);
                        r_res <= '0;
                        r_state <= cfg.bypass ? S_OUT : S_WALK;
                    end
                end
                S_WALK: begin
                    if (h_done) begin
                        if (h_cnt == '0) begin
                            r_res   <= r_nd;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (d_done) begin
                        r_res   <= lds_pkg::clamp_delta(half, cfg.max_delta);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_odata  <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_latency_delta_smoother_unit.sv -----
// Self-checking testbench for latency_delta_smoother_unit: stream words in, smoothed deltas out.
// Holds its own copy of the smoothing window and registers; needs lds_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_latency_delta_smoother_unit;

    localparam int HIST_DEPTH    = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 133;

    // mirror of the smoother: registers, history window, expected outputs
    class smoothing_tracker;
        bit                 bypass   = 1'b0;
        bit [9:0]           snap     = 10'd100;
        logic signed [10:0] fine     = 11'sd0;
        bit [14:0]          max_lim  = 15'd300;
        logic signed [15:0] hist [HIST_DEPTH];
        int                 fill     = 0;
        logic signed [15:0] smoothed_q [$];
        int                 mismatches = 0;

        function void set_reg(input logic [1:0] code, input logic [31:0] value);
            case (code)
                lds_pkg::REG_BYPASS: bypass  = value[0];
                lds_pkg::REG_SNAP:   snap    = value[9:0];
                lds_pkg::REG_FINE:   fine    = value[10:0];
                lds_pkg::REG_MAX:    max_lim = value[14:0];
                default: ;
            endcase
        endfunction

        function int clip(input int v);
            if (v < -int'(max_lim)) return -int'(max_lim);
            if (v > 0) return 0;
            return v;
        endfunction

        function void note_delta(input logic signed [15:0] raw);
            int nd;
            int total;
            int negs;
            int res;
            if (bypass) begin
                smoothed_q.push_back(16'sd0);
                return;
            end
            nd = clip(int'(raw) + int'(snap >> 1) + int'(fine));
            total = 0;
            negs = 0;
            for (int i = 0; i < fill; i++) begin
                if (hist[i] < 0) begin
                    total += int'(hist[i]);
                    negs++;
                end
            end
            res = (negs == 0) ? nd : (total / negs + nd) / 2;
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                hist[i] = hist[i - 1];
            end
            hist[0] = 16'(nd);
            if (fill < HIST_DEPTH) begin
                fill++;
            end
            smoothed_q.push_back(16'(clip(res)));
        endfunction

        function void check_smoothed(input logic signed [15:0] actual);
            logic signed [15:0] want;
            if (smoothed_q.size() == 0) begin
                $error("smoothed_delta with nothing expected: got %0d", actual);
                mismatches++;
                return;
            end
            want = smoothed_q.pop_front();
            if (actual !== want) begin
                $error("smoothed_delta mismatch: expected %0d, got %0d", want, actual);
                mismatches++;
            end
        endfunction

        function int pending();
            return smoothed_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic signed [15:0]        s_axis_tdata;   // [15:0] new_time_delta
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic signed [15:0]        m_axis_tdata;   // [15:0] smoothed_delta
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [lds_pkg::ADDR_W-1:0] paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    smoothing_tracker tracker = new;
    int  cycle_count = 0;
    bit  calm_tail   = 1'b0;
    bit  hold_req    = 1'b0;

    latency_delta_smoother_unit #(.WINDOW(HIST_DEPTH)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("latency_delta_smoother_unit verification failed");
            $finish;
        end
    end

    // results first, then the word taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_smoothed(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_delta(s_axis_tdata);
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++) begin
                    @(negedge i_clk);
                end
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    task automatic send_delta(input logic signed [15:0] d);
        int gap;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [1:0] code, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(code, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only between phases: stop offering words and let every result drain
    task automatic program_regs(input bit byp, input int snap, input int fine, input int lim);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        write_reg(lds_pkg::REG_BYPASS, 32'(byp));
        write_reg(lds_pkg::REG_SNAP, 32'(snap) & 32'h3FF);
        write_reg(lds_pkg::REG_FINE, 32'(fine) & 32'h7FF);
        write_reg(lds_pkg::REG_MAX, 32'(lim) & 32'h7FFF);
    endtask

    function automatic logic signed [15:0] pick_delta();
        int base;
        int v;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            default: begin
                base = int'(tracker.snap >> 1) + int'(tracker.fine);
                v = -int'($urandom_range(0, int'(tracker.max_lim) + 200)) - base
                    + int'($urandom_range(0, 40)) - 20;
                if (v < -32768) v = -32768;
                if (v > 32767) v = 32767;
                return 16'(v);
            end
        endcase
    endfunction

    logic signed [15:0] warmup [12] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, -16'sd50,
                                        -16'sd51, -16'sd349, -16'sd350, -16'sd351,
                                        16'sd49, -16'sd120, -16'sd1000};

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, empty then filling history
        foreach (warmup[k]) send_delta(warmup[k]);

        // bypass leaves the window alone
        program_regs(1'b1, 100, 0, 300);
        send_delta(-16'sd32768);
        send_delta(16'sd32767);
        send_delta(-16'sd200);
        program_regs(1'b0, 100, 0, 300);
        send_delta(-16'sd150);

        // zero clamp range: everything collapses to zero
        program_regs(1'b0, 0, 0, 0);
        send_delta(-16'sd32768);
        send_delta(-16'sd1);
        send_delta(16'sd0);
        send_delta(16'sd32767);

        // widest clamp, largest frame time, most negative fine nudge
        program_regs(1'b0, 1023, -1024, 32767);
        send_delta(-16'sd32768);
        send_delta(16'sd32767);
        send_delta(-16'sd1);
        send_delta(-16'sd20000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: program_regs(1'b0, 1000, 1000, 32767);
                1: program_regs(1'b0, 0, -1000, 300);
                default: program_regs($urandom_range(0, 7) == 0, $urandom_range(0, 1023),
                                      $urandom_range(0, 2047),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                                  : $urandom_range(0, 600));
            endcase
            if (p == 3) hold_req = 1'b1;
            if (p == RANDOM_PHASES - 1) calm_tail = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_delta(pick_delta());
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("latency_delta_smoother_unit verification clean");
        end else begin
            $display("latency_delta_smoother_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lds_pkg.sv
rtl/lds_cfg.sv
rtl/lds_hist.sv
rtl/lds_div.sv
rtl/latency_delta_smoother_unit.sv
verif/tb_latency_delta_smoother_unit.sv
